/* sv/led_blink_pattern_sequencer_core_assert.svh */
// assertion macros for the led blink pattern sequencer
`ifndef LED_BLINK_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_CORE_ASSERT_SVH

// antecedent holds, consequent must follow in the next cycle
`define LBPS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

// condition holds in every cycle out of reset
`define LBPS_ASSERT_ALWAYS(label, clk, rst_n, a, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
		else $error(msg);

`endif

/* sv/lbps_pkg.sv */
// package with types, codes and pattern rom of the led blink pattern sequencer
package lbps_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int NOW_W          = 32;
	localparam int MODE_W         = 5;
	localparam int PULSE_W        = 16;
	localparam int OP_W           = 2;
	localparam int STEP_W         = 4;
	localparam int DUR_W          = 12;
	localparam int MAX_STEPS      = 12;

	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_SET   = 2'd1;
	localparam logic [OP_W-1:0] OP_PULSE = 2'd2;

	localparam logic [MODE_W-1:0] MODE_OFF          = 5'd0;
	localparam logic [MODE_W-1:0] MODE_IDLE         = 5'd1;
	localparam logic [MODE_W-1:0] MODE_BOOT         = 5'd2;
	localparam logic [MODE_W-1:0] MODE_PAIRING      = 5'd3;
	localparam logic [MODE_W-1:0] MODE_JOINING      = 5'd4;
	localparam logic [MODE_W-1:0] MODE_DEBUG_CONF   = 5'd5;
	localparam logic [MODE_W-1:0] MODE_SUCCESS_ONCE = 5'd6;
	localparam logic [MODE_W-1:0] MODE_SUCCESS_DBL  = 5'd7;
	localparam logic [MODE_W-1:0] MODE_ERROR_REP    = 5'd8;
	localparam logic [MODE_W-1:0] MODE_ERROR_ONCE   = 5'd9;
	localparam logic [MODE_W-1:0] MODE_FACTORY      = 5'd10;
	localparam logic [MODE_W-1:0] MODE_CAL_ENTER    = 5'd11;
	localparam logic [MODE_W-1:0] MODE_CAL_DRY      = 5'd12;
	localparam logic [MODE_W-1:0] MODE_CAL_WET      = 5'd13;
	localparam logic [MODE_W-1:0] MODE_CAL_PROMPT   = 5'd14;
	localparam logic [MODE_W-1:0] MODE_CAL_DONE     = 5'd15;
	localparam logic [MODE_W-1:0] MODE_CAL_ERR_REP  = 5'd16;
	localparam logic [MODE_W-1:0] MODE_COUNT        = 5'd17;

	typedef enum logic [3:0] {
		PAT_NONE,
		PAT_BOOT,
		PAT_PAIR,
		PAT_JOIN,
		PAT_SUCC,
		PAT_DBL,
		PAT_ERR,
		PAT_FACT,
		PAT_CAL,
		PAT_MEAS,
		PAT_WET
	} pat_t;

	typedef struct packed {
		logic [STEP_W-1:0] len;
		logic              loops;
		logic              once;
		pat_t              pat;
	} mode_desc_t;

	function automatic mode_desc_t mode_desc(input logic [MODE_W-1:0] m);
		mode_desc_t d;
		d = '{len: 4'd0, loops: 1'b0, once: 1'b0, pat: PAT_NONE};
		unique case (m)
			MODE_BOOT:         d = '{len: 4'd4,  loops: 1'b0, once: 1'b1, pat: PAT_BOOT};
			MODE_PAIRING:      d = '{len: 4'd4,  loops: 1'b1, once: 1'b0, pat: PAT_PAIR};
			MODE_JOINING:      d = '{len: 4'd2,  loops: 1'b1, once: 1'b0, pat: PAT_JOIN};
			MODE_DEBUG_CONF:   d = '{len: 4'd2,  loops: 1'b0, once: 1'b1, pat: PAT_SUCC};
			MODE_SUCCESS_ONCE: d = '{len: 4'd2,  loops: 1'b0, once: 1'b1, pat: PAT_SUCC};
			MODE_SUCCESS_DBL:  d = '{len: 4'd4,  loops: 1'b0, once: 1'b1, pat: PAT_DBL};
			MODE_ERROR_REP:    d = '{len: 4'd6,  loops: 1'b1, once: 1'b0, pat: PAT_ERR};
			MODE_ERROR_ONCE:   d = '{len: 4'd6,  loops: 1'b0, once: 1'b1, pat: PAT_ERR};
			MODE_FACTORY:      d = '{len: 4'd12, loops: 1'b0, once: 1'b1, pat: PAT_FACT};
			MODE_CAL_ENTER:    d = '{len: 4'd10, loops: 1'b0, once: 1'b1, pat: PAT_CAL};
			MODE_CAL_DRY:      d = '{len: 4'd2,  loops: 1'b1, once: 1'b0, pat: PAT_MEAS};
			MODE_CAL_WET:      d = '{len: 4'd2,  loops: 1'b1, once: 1'b0, pat: PAT_MEAS};
			MODE_CAL_PROMPT:   d = '{len: 4'd4,  loops: 1'b1, once: 1'b0, pat: PAT_WET};
			MODE_CAL_DONE:     d = '{len: 4'd2,  loops: 1'b0, once: 1'b1, pat: PAT_SUCC};
			MODE_CAL_ERR_REP:  d = '{len: 4'd6,  loops: 1'b1, once: 1'b0, pat: PAT_ERR};
			default:           d = '{len: 4'd0,  loops: 1'b0, once: 1'b0, pat: PAT_NONE};
		endcase
		return d;
	endfunction

	// every pattern starts lit and alternates, so only the duration is stored
	function automatic logic [DUR_W-1:0] step_ms(input pat_t p, input logic [STEP_W-1:0] idx);
		logic [DUR_W-1:0] ms;
		ms = '0;
		unique case (p)
			PAT_BOOT: ms = idx[0] ? 12'd150 : 12'd500;
			PAT_PAIR: ms = (idx == 4'd3) ? 12'd700 : 12'd100;
			PAT_JOIN: ms = idx[0] ? 12'd700 : 12'd300;
			PAT_SUCC: ms = idx[0] ? 12'd600 : 12'd3000;
			PAT_DBL:  ms = idx[0] ? 12'd300 : 12'd1500;
			PAT_ERR:  ms = 12'd100;
			PAT_FACT: ms = 12'd80;
			PAT_CAL:  ms = 12'd80;
			PAT_MEAS: ms = 12'd500;
			PAT_WET:  ms = (idx == 4'd3) ? 12'd800 : 12'd400;
			default:  ms = '0;
		endcase
		return ms;
	endfunction

endpackage

/* sv/lbps_if.sv */
// stream interfaces for the command, result and configuration channels
interface lbps_cmd_if import lbps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    opcode;
	logic [NOW_W-1:0]   now_ms;
	logic [MODE_W-1:0]  mode;
	logic [PULSE_W-1:0] pulse_ms;

	modport source (output valid, output opcode, output now_ms, output mode,
		output pulse_ms, input ready);
	modport sink (input valid, input opcode, input now_ms, input mode,
		input pulse_ms, output ready);
endinterface

interface lbps_led_if import lbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              led_level;
	logic              pattern_on;
	logic [MODE_W-1:0] current_mode;

	modport source (output valid, output led_level, output pattern_on,
		output current_mode, input ready);
	modport sink (input valid, input led_level, input pattern_on,
		input current_mode, output ready);
endinterface

interface lbps_cfg_if ();
	logic valid;
	logic ready;
	logic active_high;

	modport source (output valid, output active_high, input ready);
	modport sink (input valid, input active_high, output ready);
endinterface

/* sv/led_blink_pattern_sequencer_core.sv */
// top level of the led blink pattern sequencer
//
// cmd carries one operation per transaction: tick, set mode or pulse.
// only a tick produces a transaction on led, giving the led level after
// polarity, the raw pattern bit and the mode in effect after that tick.
// set mode and pulse update internal state and produce nothing.
// cfg writes the polarity bit; it is always ready and should only be
// written while no command is in flight.
// a command is registered in stage one and processed there; a tick result
// is then registered in the output register and leaves from it on led.
// throughput: one command per cycle while no tick is held by a led stall;
// the loop is the update of the pattern state from stage one.
// when led stalls, a tick waits in stage one while the output register is
// full, which drops cmd ready; set mode and pulse still pass.
// reset starts the boot pattern at time zero with no pulse pending and the
// polarity active high; both channels come up empty.
`include "led_blink_pattern_sequencer_core_assert.svh"

module led_blink_pattern_sequencer_core import lbps_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lbps_cfg_if.sink   cfg,
	lbps_cmd_if.sink   cmd,
	lbps_led_if.source led
);

	logic                  valid_s1;
	logic [OP_W-1:0]       opcode_s1;
	logic [NOW_W-1:0]      now_s1;
	logic [MODE_W-1:0]     mode_s1;
	logic [PULSE_W-1:0]    pulse_s1;

	logic                  active_high_q;
	logic [MODE_W-1:0]     active_mode_q;
	logic [MODE_W-1:0]     restore_mode_q;
	logic [STEP_W-1:0]     step_idx_q;
	logic [TIME_WIDTH-1:0] step_start_q;
	logic [TIME_WIDTH-1:0] pulse_until_q;

	logic                  out_valid_q;
	logic                  led_level_q;
	logic                  pattern_on_q;
	logic [MODE_W-1:0]     current_mode_q;

	logic                  out_free;
	logic                  s1_go;

	logic [TIME_WIDTH-1:0] now_t;
	mode_desc_t            d_act;
	mode_desc_t            d_req;
	logic                  restart;
	logic [STEP_W-1:0]     idx_eff;
	logic [TIME_WIDTH-1:0] start_eff;
	logic [TIME_WIDTH-1:0] elapsed;
	logic [DUR_W-1:0]      dur;
	logic                  lit;

	logic [MODE_W-1:0]     adv_mode;
	logic [STEP_W-1:0]     adv_idx;
	logic [TIME_WIDTH-1:0] adv_start;
	logic                  adv_base;

	logic [TIME_WIDTH-1:0] pulse_diff;
	logic                  pulse_act;
	logic                  on_bit;
	logic [TIME_WIDTH-1:0] until_t;
	logic [TIME_WIDTH-1:0] until_diff;
	logic                  until_later;

	assign out_free  = !out_valid_q || led.ready;
	assign s1_go     = valid_s1 && ((opcode_s1 != OP_TICK) || out_free);
	assign cmd.ready = !valid_s1 || s1_go;
	assign cfg.ready = 1'b1;

	assign led.valid        = out_valid_q;
	assign led.led_level    = led_level_q;
	assign led.pattern_on   = pattern_on_q;
	assign led.current_mode = current_mode_q;

	assign now_t = TIME_WIDTH'(now_s1);
	assign d_act = mode_desc(active_mode_q);
	assign d_req = mode_desc(mode_s1);

	// pattern advance for a tick
	always_comb begin
		restart   = (step_idx_q >= d_act.len);
		idx_eff   = restart ? '0 : step_idx_q;
		start_eff = restart ? now_t : step_start_q;
		lit       = !idx_eff[0];
		dur       = step_ms(d_act.pat, idx_eff);
		elapsed   = now_t - start_eff;
		adv_mode  = active_mode_q;
		adv_idx   = idx_eff;
		adv_start = start_eff;
		adv_base  = lit;
		if (d_act.len == '0) begin
			adv_idx   = step_idx_q;
			adv_start = step_start_q;
			adv_base  = 1'b0;
		end else if (elapsed >= TIME_WIDTH'(dur)) begin
			adv_start = now_t;
			if ((idx_eff + STEP_W'(1)) < d_act.len) begin
				adv_idx = idx_eff + STEP_W'(1);
			end else begin
				adv_idx = '0;
				if (!d_act.loops) begin
					priority if (active_mode_q == MODE_FACTORY) begin
						adv_mode = MODE_SUCCESS_ONCE;
					end else if (d_act.once) begin
						adv_mode = restore_mode_q;
					end else begin
						adv_mode = MODE_OFF;
					end
				end
			end
		end
	end

	// pulse overlay compares, signed modulo the time width
	always_comb begin
		pulse_diff  = pulse_until_q - now_t;
		pulse_act   = (pulse_diff != '0) && !pulse_diff[TIME_WIDTH-1];
		on_bit      = adv_base || pulse_act;
		until_t     = now_t + TIME_WIDTH'(pulse_s1);
		until_diff  = until_t - pulse_until_q;
		until_later = (until_diff != '0) && !until_diff[TIME_WIDTH-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			opcode_s1 <= cmd.opcode;
			now_s1    <= cmd.now_ms;
			mode_s1   <= cmd.mode;
			pulse_s1  <= cmd.pulse_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			active_high_q <= cfg.active_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_mode_q  <= MODE_BOOT;
			restore_mode_q <= MODE_OFF;
			step_idx_q     <= '0;
			step_start_q   <= '0;
			pulse_until_q  <= '0;
		end else if (s1_go) begin
			unique case (opcode_s1)
				OP_TICK: begin
					active_mode_q <= adv_mode;
					step_idx_q    <= adv_idx;
					step_start_q  <= adv_start;
				end
				OP_SET: begin
					if (mode_s1 < MODE_COUNT) begin
						if (d_req.once) begin
							if (!d_act.once) begin
								restore_mode_q <= active_mode_q;
							end
							active_mode_q <= mode_s1;
							step_idx_q    <= '0;
							step_start_q  <= now_t;
						end else if (d_act.once) begin
							restore_mode_q <= mode_s1;
						end else begin
							active_mode_q <= mode_s1;
							step_idx_q    <= '0;
							step_start_q  <= now_t;
						end
					end
				end
				OP_PULSE: begin
					if (until_later) begin
						pulse_until_q <= until_t;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && (opcode_s1 == OP_TICK)) begin
			out_valid_q <= 1'b1;
		end else if (led.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (opcode_s1 == OP_TICK)) begin
			led_level_q    <= active_high_q ? on_bit : !on_bit;
			pattern_on_q   <= adv_base;
			current_mode_q <= adv_mode;
		end
	end

	`LBPS_ASSERT_NEXT(a_tick_gives_result, clk, arst_n,
		valid_s1 && (opcode_s1 == OP_TICK) && out_free, out_valid_q, "tick lost its result")
	`LBPS_ASSERT_ALWAYS(a_stall_only_on_tick, clk, arst_n,
		cmd.ready || (valid_s1 && (opcode_s1 == OP_TICK) && out_valid_q && !led.ready),
		"command channel stalled without a blocked tick")
	`LBPS_ASSERT_ALWAYS(a_mode_in_range, clk, arst_n,
		(active_mode_q < MODE_COUNT) && (restore_mode_q < MODE_COUNT), "mode out of range")
	`LBPS_ASSERT_ALWAYS(a_step_in_range, clk, arst_n,
		step_idx_q < STEP_W'(MAX_STEPS), "step index beyond longest pattern")

endmodule
